[src/rgb_led_matrix_scan_driver_core_assert.svh]
// ----------------------------------------------------------------------------
// RGB LED matrix scan driver - assertion macros
// Shared concurrent assertion forms, clocked on the rising edge with a
// reset that disables checking.
// ----------------------------------------------------------------------------
`ifndef RGB_LED_MATRIX_SCAN_DRIVER_CORE_ASSERT_SVH
`define RGB_LED_MATRIX_SCAN_DRIVER_CORE_ASSERT_SVH

// same-cycle implication
`define RLMS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RLMS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/rlms_pkg.sv]
// ----------------------------------------------------------------------------
// RGB LED matrix scan driver - package
// Payload types, scan control bundle and shared constants.
// ----------------------------------------------------------------------------
`default_nettype none

package rlms_pkg;

  localparam int PANEL_ROWS_DEF = 32;
  localparam int PANEL_COLS_DEF = 64;
  localparam int COLOR_BITS_DEF = 8;

  localparam int COLOR_W    = 8;
  localparam int PIXEL_W    = 3 * COLOR_W;
  localparam int PLANE_W    = 3;
  localparam int LIT_CNT_W  = 16;
  localparam int ROW_ADDR_W = 4;
  localparam int PULSE_W    = 8;

  localparam logic [PULSE_W-1:0] PULSE_BASE_RESET = 8'd4;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  typedef struct packed {
    logic                 operation;
    logic [4:0]           pixel_row;
    logic [5:0]           pixel_col;
    logic [COLOR_W-1:0]   red;
    logic [COLOR_W-1:0]   green;
    logic [COLOR_W-1:0]   blue;
  } in_item_t;

  typedef struct packed {
    logic                  red_top;
    logic                  green_top;
    logic                  blue_top;
    logic                  red_bottom;
    logic                  green_bottom;
    logic                  blue_bottom;
    logic                  shift_clock;
    logic                  latch;
    logic                  display_on;
    logic [ROW_ADDR_W-1:0] row_address;
    logic                  frame_done;
  } out_item_t;

  // per-tick pin control from the scan sequencer
  typedef struct packed {
    logic                  data_en;
    logic [PLANE_W-1:0]    plane;
    logic                  shift_clock;
    logic                  latch;
    logic                  display_on;
    logic [ROW_ADDR_W-1:0] row_address;
    logic                  frame_done;
  } scan_ctrl_t;

endpackage

`default_nettype wire

[src/rlms_frame.sv]
// ----------------------------------------------------------------------------
// RGB LED matrix scan driver - frame store
// One write port, two registered read ports, zero-fill pass after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module rlms_frame #(
  parameter int PANEL_ROWS = rlms_pkg::PANEL_ROWS_DEF,
  parameter int PANEL_COLS = rlms_pkg::PANEL_COLS_DEF
) (
  input  wire logic                                         clk,
  input  wire logic                                         rst,
  input  wire logic                                         wr_en,
  input  wire logic [$clog2(PANEL_ROWS*PANEL_COLS)-1:0]     wr_addr,
  input  wire logic [rlms_pkg::PIXEL_W-1:0]                 wr_data,
  input  wire logic                                         rd_en,
  input  wire logic [$clog2(PANEL_ROWS*PANEL_COLS)-1:0]     rd_addr_top,
  input  wire logic [$clog2(PANEL_ROWS*PANEL_COLS)-1:0]     rd_addr_bot,
  output logic      [rlms_pkg::PIXEL_W-1:0]                 rd_data_top,
  output logic      [rlms_pkg::PIXEL_W-1:0]                 rd_data_bot,
  output logic                                              busy
);

  localparam int DEPTH  = PANEL_ROWS * PANEL_COLS;
  localparam int ADDR_W = $clog2(DEPTH);

  logic [rlms_pkg::PIXEL_W-1:0] mem [DEPTH];

  logic              clearing;
  logic [ADDR_W-1:0] clr_addr;

  logic                         mem_we;
  logic [ADDR_W-1:0]            mem_waddr;
  logic [rlms_pkg::PIXEL_W-1:0] mem_wdata;

  assign busy      = clearing;
  assign mem_we    = clearing | wr_en;
  assign mem_waddr = clearing ? clr_addr : wr_addr;
  assign mem_wdata = clearing ? '0 : wr_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      if (clr_addr == ADDR_W'(DEPTH - 1)) begin
        clearing <= 1'b0;
      end
      clr_addr <= clr_addr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rd_data_top <= mem[rd_addr_top];
      rd_data_bot <= mem[rd_addr_bot];
    end
  end

endmodule

`default_nettype wire

[src/rlms_scan.sv]
// ----------------------------------------------------------------------------
// RGB LED matrix scan driver - scan sequencer
// Walks row pair, bit plane, column and phase; registers per-tick pin control.
// ----------------------------------------------------------------------------
`default_nettype none

module rlms_scan #(
  parameter int PANEL_ROWS = rlms_pkg::PANEL_ROWS_DEF,
  parameter int PANEL_COLS = rlms_pkg::PANEL_COLS_DEF,
  parameter int COLOR_BITS = rlms_pkg::COLOR_BITS_DEF
) (
  input  wire logic                                     clk,
  input  wire logic                                     rst,
  input  wire logic                                     tick_en,
  input  wire logic [rlms_pkg::PULSE_W-1:0]             pulse_base,
  output logic      [$clog2(PANEL_ROWS*PANEL_COLS)-1:0] rd_addr_top,
  output logic      [$clog2(PANEL_ROWS*PANEL_COLS)-1:0] rd_addr_bot,
  output rlms_pkg::scan_ctrl_t                          ctrl
);

  localparam int HALF_ROWS = PANEL_ROWS / 2;
  localparam int ADDR_W    = $clog2(PANEL_ROWS * PANEL_COLS);
  localparam int PAIR_W    = (HALF_ROWS > 1) ? $clog2(HALF_ROWS) : 1;
  localparam int COL_W     = (PANEL_COLS > 1) ? $clog2(PANEL_COLS) : 1;

  typedef enum logic [2:0] {
    PH_SHIFT_LOW  = 3'd0,
    PH_SHIFT_HIGH = 3'd1,
    PH_ADDRESS    = 3'd2,
    PH_LATCH      = 3'd3,
    PH_LIT        = 3'd4
  } phase_t;

  phase_t                              phase, phase_next;
  logic [PAIR_W-1:0]                   pair, pair_next;
  logic [rlms_pkg::PLANE_W-1:0]        plane, plane_next;
  logic [COL_W-1:0]                    col, col_next;
  logic [rlms_pkg::LIT_CNT_W-1:0]      lit_cnt, lit_cnt_next;
  logic [rlms_pkg::ROW_ADDR_W-1:0]     addr_hold, addr_hold_next;
  rlms_pkg::scan_ctrl_t                ctrl_next;

  logic [rlms_pkg::LIT_CNT_W-1:0]      lit_target;
  logic [rlms_pkg::LIT_CNT_W-1:0]      lit_inc;
  logic [7:0]                          pair_ext;

  assign rd_addr_top = ADDR_W'(int'(pair) * PANEL_COLS + int'(col));
  assign rd_addr_bot = ADDR_W'((int'(pair) + HALF_ROWS) * PANEL_COLS + int'(col));

  assign lit_target = rlms_pkg::LIT_CNT_W'({8'h00, pulse_base} << plane);
  assign lit_inc    = lit_cnt + 1'b1;
  assign pair_ext   = 8'(pair);

  always_comb begin
    phase_next     = phase;
    pair_next      = pair;
    plane_next     = plane;
    col_next       = col;
    lit_cnt_next   = lit_cnt;
    addr_hold_next = addr_hold;
    ctrl_next      = '0;
    ctrl_next.plane = plane;

    case (phase)
      PH_SHIFT_HIGH: begin
        ctrl_next.data_en     = 1'b1;
        ctrl_next.shift_clock = 1'b1;
        if (col == COL_W'(PANEL_COLS - 1)) begin
          col_next   = '0;
          phase_next = PH_ADDRESS;
        end else begin
          col_next   = col + 1'b1;
          phase_next = PH_SHIFT_LOW;
        end
      end
      PH_ADDRESS: begin
        addr_hold_next = pair_ext[rlms_pkg::ROW_ADDR_W-1:0];
        phase_next     = PH_LATCH;
      end
      PH_LATCH: begin
        ctrl_next.latch = 1'b1;
        lit_cnt_next    = '0;
        phase_next      = PH_LIT;
      end
      PH_LIT: begin
        ctrl_next.display_on = 1'b1;
        lit_cnt_next         = lit_inc;
        if (lit_inc >= lit_target) begin
          lit_cnt_next = '0;
          phase_next   = PH_SHIFT_LOW;
          if (plane == rlms_pkg::PLANE_W'(COLOR_BITS - 1)) begin
            plane_next = '0;
            if (pair == PAIR_W'(HALF_ROWS - 1)) begin
              pair_next            = '0;
              ctrl_next.frame_done = 1'b1;
            end else begin
              pair_next = pair + 1'b1;
            end
          end else begin
            plane_next = plane + 1'b1;
          end
        end
      end
      default: begin
        // clock-low shift tick; unused codes behave the same
        ctrl_next.data_en = 1'b1;
        phase_next        = PH_SHIFT_HIGH;
      end
    endcase

    ctrl_next.row_address = addr_hold_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_SHIFT_LOW;
      pair      <= '0;
      plane     <= '0;
      col       <= '0;
      lit_cnt   <= '0;
      addr_hold <= '0;
      ctrl      <= '0;
    end else if (tick_en) begin
      phase     <= phase_next;
      pair      <= pair_next;
      plane     <= plane_next;
      col       <= col_next;
      lit_cnt   <= lit_cnt_next;
      addr_hold <= addr_hold_next;
      ctrl      <= ctrl_next;
    end
  end

endmodule

`default_nettype wire

[src/rgb_led_matrix_scan_driver_core.sv]
// Pipeline: stage 1 and the output register, two register stages to out_valid.
// Throughput: one item per cycle unless the frame store is clearing or a
//   stalled output backs up stage 1; the frame store read and the scan step
//   run in the transfer cycle, the bit-plane select runs in the next one.
// Reset: the frame store is zero-filled one entry per cycle, all PANEL_ROWS *
//   PANEL_COLS entries (2048 by default) with in_ready low; cfg_ready stays high.
// ----------------------------------------------------------------------------
// RGB LED matrix scan driver - top level
// Row-pair scanned panel driver with binary code modulation from a stored
// frame; pixel writes and scan ticks share one input channel.
// ----------------------------------------------------------------------------
`default_nettype none

`include "rgb_led_matrix_scan_driver_core_assert.svh"

module rgb_led_matrix_scan_driver_core #(
  parameter int PANEL_ROWS = rlms_pkg::PANEL_ROWS_DEF,
  parameter int PANEL_COLS = rlms_pkg::PANEL_COLS_DEF,
  parameter int COLOR_BITS = rlms_pkg::COLOR_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // item channel
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire rlms_pkg::in_item_t            in_data,
  // result channel
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output rlms_pkg::out_item_t                out_data,
  // pulse base register write
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [rlms_pkg::PULSE_W-1:0]  cfg_data
);

  localparam int ADDR_W = $clog2(PANEL_ROWS * PANEL_COLS);

  // ---------------------------------------------------------------------------
  // Configuration: single register, always ready.
  // ---------------------------------------------------------------------------
  logic [rlms_pkg::PULSE_W-1:0] pulse_base;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pulse_base <= rlms_pkg::PULSE_BASE_RESET;
    end else if (cfg_valid) begin
      pulse_base <= cfg_data;
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline control. Stage 1 holds the item whose frame data and scan
  // control were registered at transfer; the output register parts the
  // result side so a new item can enter while a result waits.
  // ---------------------------------------------------------------------------
  logic frame_busy;
  logic s1_valid;
  logic s1_op;
  logic advance;
  logic in_xfer;
  logic tick_en;
  logic wr_en;
  logic [ADDR_W-1:0] wr_addr;

  assign advance  = !out_valid || out_ready;
  assign in_ready = !frame_busy && (!s1_valid || advance);
  assign in_xfer  = in_valid && in_ready;
  assign tick_en  = in_xfer && (in_data.operation == rlms_pkg::OP_TICK);

  // writes outside the panel are dropped
  assign wr_en   = in_xfer && (in_data.operation == rlms_pkg::OP_WRITE)
                   && (int'(in_data.pixel_row) < PANEL_ROWS)
                   && (int'(in_data.pixel_col) < PANEL_COLS);
  assign wr_addr = ADDR_W'(int'(in_data.pixel_row) * PANEL_COLS
                           + int'(in_data.pixel_col));

  // ---------------------------------------------------------------------------
  // Scan sequencer and frame store
  // ---------------------------------------------------------------------------
  logic [ADDR_W-1:0]            rd_addr_top;
  logic [ADDR_W-1:0]            rd_addr_bot;
  logic [rlms_pkg::PIXEL_W-1:0] rd_data_top;
  logic [rlms_pkg::PIXEL_W-1:0] rd_data_bot;
  rlms_pkg::scan_ctrl_t         s1_ctrl;

  rlms_scan #(
    .PANEL_ROWS (PANEL_ROWS),
    .PANEL_COLS (PANEL_COLS),
    .COLOR_BITS (COLOR_BITS)
  ) u_scan (
    .clk         (clk),
    .rst         (rst),
    .tick_en     (tick_en),
    .pulse_base  (pulse_base),
    .rd_addr_top (rd_addr_top),
    .rd_addr_bot (rd_addr_bot),
    .ctrl        (s1_ctrl)
  );

  // the frame read is taken on every tick transfer; only shift ticks use it
  rlms_frame #(
    .PANEL_ROWS (PANEL_ROWS),
    .PANEL_COLS (PANEL_COLS)
  ) u_frame (
    .clk         (clk),
    .rst         (rst),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .wr_data     ({in_data.red, in_data.green, in_data.blue}),
    .rd_en       (tick_en),
    .rd_addr_top (rd_addr_top),
    .rd_addr_bot (rd_addr_bot),
    .rd_data_top (rd_data_top),
    .rd_data_bot (rd_data_bot),
    .busy        (frame_busy)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s1_op    <= rlms_pkg::OP_WRITE;
    end else begin
      if (in_ready) begin
        s1_valid <= in_valid;
      end
      if (in_xfer) begin
        s1_op <= in_data.operation;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result formation. A tick picks the current plane bit out of each colour
  // channel. A write repeats the last pin levels, which the output register
  // still holds, with latch and frame_done forced low.
  // ---------------------------------------------------------------------------
  logic [rlms_pkg::COLOR_W-1:0] r_top, g_top, b_top;
  logic [rlms_pkg::COLOR_W-1:0] r_bot, g_bot, b_bot;
  rlms_pkg::out_item_t          result;

  assign {r_top, g_top, b_top} = rd_data_top;
  assign {r_bot, g_bot, b_bot} = rd_data_bot;

  always_comb begin
    if (s1_op == rlms_pkg::OP_TICK) begin
      result.red_top      = s1_ctrl.data_en & r_top[s1_ctrl.plane];
      result.green_top    = s1_ctrl.data_en & g_top[s1_ctrl.plane];
      result.blue_top     = s1_ctrl.data_en & b_top[s1_ctrl.plane];
      result.red_bottom   = s1_ctrl.data_en & r_bot[s1_ctrl.plane];
      result.green_bottom = s1_ctrl.data_en & g_bot[s1_ctrl.plane];
      result.blue_bottom  = s1_ctrl.data_en & b_bot[s1_ctrl.plane];
      result.shift_clock  = s1_ctrl.shift_clock;
      result.latch        = s1_ctrl.latch;
      result.display_on   = s1_ctrl.display_on;
      result.row_address  = s1_ctrl.row_address;
      result.frame_done   = s1_ctrl.frame_done;
    end else begin
      result            = out_data;
      result.latch      = 1'b0;
      result.frame_done = 1'b0;
    end
  end

  // output register; reset to all zeros since it doubles as the held pin state
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      out_data  <= '0;
    end else if (advance) begin
      out_valid <= s1_valid;
      if (s1_valid) begin
        out_data <= result;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `RLMS_ASSERT_NOW(a_no_xfer_while_clearing, clk, rst, frame_busy, !in_ready,
    "input transfer allowed during frame clear")
  `RLMS_ASSERT_NEXT(a_s1_holds_on_stall, clk, rst, s1_valid && !advance, s1_valid,
    "stage 1 item lost while output stalled")
  `RLMS_ASSERT_NOW(a_latch_not_lit, clk, rst, out_valid,
    !(out_data.latch && out_data.display_on), "latch and display_on both high")
  `RLMS_ASSERT_NOW(a_done_while_lit, clk, rst, out_valid && out_data.frame_done,
    out_data.display_on, "frame_done outside a lit tick")

endmodule

`default_nettype wire

[verif/tb_rgb_led_matrix_scan_driver_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB LED matrix scan driver - testbench
// Drives pixel writes and scan ticks into the core under random handshake
// pressure, predicts every pin result with a scan model kept in the bench,
// and checks each result transfer field by field in order.
// ----------------------------------------------------------------------------

module tb_rgb_led_matrix_scan_driver_core;

  localparam int HALF_ROWS   = rlms_pkg::PANEL_ROWS_DEF / 2;
  localparam int FRAME_DEPTH = rlms_pkg::PANEL_ROWS_DEF * rlms_pkg::PANEL_COLS_DEF;
  localparam int LONG_STALL  = 600;    // receiver hold-off, long enough to back up the core
  localparam int QUIET_LIMIT = 20000;  // covers the reset clear pass several times over
  localparam int MAX_WAIT    = 17;

  typedef enum logic [2:0] {
    PH_SHIFT_LOW, PH_SHIFT_HIGH, PH_ADDRESS, PH_LATCH, PH_LIT
  } scan_phase_t;

  typedef enum int {IDLE_NONE, IDLE_SPARSE, IDLE_HEAVY} idle_mode_t;

  logic clk;
  logic rst;

  logic                          in_valid = 1'b0;
  logic                          in_ready;
  rlms_pkg::in_item_t            in_data = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  rlms_pkg::out_item_t           out_data;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [rlms_pkg::PULSE_W-1:0]  cfg_data;

  rgb_led_matrix_scan_driver_core dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // --------------------------------------------------------------------------
  // Scan model: frame copy, scan counters and the pins of the last tick
  // --------------------------------------------------------------------------
  logic [rlms_pkg::PIXEL_W-1:0]    panel_frame [0:FRAME_DEPTH-1];
  logic [3:0]                      scan_pair;
  logic [rlms_pkg::PLANE_W-1:0]    scan_plane;
  logic [5:0]                      scan_col;
  scan_phase_t                     scan_phase;
  logic [rlms_pkg::LIT_CNT_W-1:0]  lit_count;
  logic [rlms_pkg::ROW_ADDR_W-1:0] row_hold;
  logic [rlms_pkg::PULSE_W-1:0]    pulse_base;
  rlms_pkg::out_item_t             held_pins;

  rlms_pkg::in_item_t  pending_items[$];   // items waiting for the driver
  rlms_pkg::out_item_t expected_pins[$];   // predicted results, oldest first

  idle_mode_t send_mode = IDLE_NONE;
  idle_mode_t recv_mode = IDLE_NONE;
  int unsigned send_gap = 0;
  int unsigned recv_wait = 0;
  int unsigned stall_left = 0;
  int stall_requests = 0;
  int stalls_served = 0;
  int mismatch_count = 0;
  int unsigned quiet_cycles = 0;

  // Current plane bit of the top and bottom pixel of the column being shifted.
  function automatic rlms_pkg::out_item_t with_column_bits(rlms_pkg::out_item_t pins);
    logic [rlms_pkg::PIXEL_W-1:0] top_px;
    logic [rlms_pkg::PIXEL_W-1:0] bottom_px;
    top_px    = panel_frame[{1'b0, scan_pair, scan_col}];
    bottom_px = panel_frame[{1'b1, scan_pair, scan_col}];
    pins.red_top      = top_px[16 + scan_plane];
    pins.green_top    = top_px[8 + scan_plane];
    pins.blue_top     = top_px[scan_plane];
    pins.red_bottom   = bottom_px[16 + scan_plane];
    pins.green_bottom = bottom_px[8 + scan_plane];
    pins.blue_bottom  = bottom_px[scan_plane];
    return pins;
  endfunction

  // One accepted item through the scan model; returns the pins it yields.
  function automatic rlms_pkg::out_item_t advance_scan_model(rlms_pkg::in_item_t item);
    rlms_pkg::out_item_t pins;
    logic [rlms_pkg::LIT_CNT_W-1:0] lit_target;
    pins = '0;
    if (item.operation == rlms_pkg::OP_WRITE) begin
      panel_frame[{item.pixel_row, item.pixel_col}] = {item.red, item.green, item.blue};
      // a write only echoes the last tick, without its one-shot strobes
      pins = held_pins;
      pins.latch = 1'b0;
      pins.frame_done = 1'b0;
      return pins;
    end
    case (scan_phase)
      PH_SHIFT_HIGH: begin
        pins = with_column_bits(pins);
        pins.shift_clock = 1'b1;
        if (scan_col == rlms_pkg::PANEL_COLS_DEF - 1) begin
          scan_col = '0;
          scan_phase = PH_ADDRESS;
        end else begin
          scan_col = scan_col + 1'b1;
          scan_phase = PH_SHIFT_LOW;
        end
      end
      PH_ADDRESS: begin
        row_hold = scan_pair;
        scan_phase = PH_LATCH;
      end
      PH_LATCH: begin
        pins.latch = 1'b1;
        lit_count = '0;
        scan_phase = PH_LIT;
      end
      PH_LIT: begin
        // zero base still lights one tick: count reaches target at once
        lit_target = pulse_base;
        lit_target = lit_target << scan_plane;
        pins.display_on = 1'b1;
        lit_count = lit_count + 1'b1;
        if (lit_count >= lit_target) begin
          lit_count = '0;
          scan_phase = PH_SHIFT_LOW;
          if (scan_plane == rlms_pkg::COLOR_BITS_DEF - 1) begin
            scan_plane = '0;
            if (scan_pair == HALF_ROWS - 1) begin
              scan_pair = '0;
              pins.frame_done = 1'b1;
            end else begin
              scan_pair = scan_pair + 1'b1;
            end
          end else begin
            scan_plane = scan_plane + 1'b1;
          end
        end
      end
      default: begin
        // clock-low half of a column
        pins = with_column_bits(pins);
        scan_phase = PH_SHIFT_HIGH;
      end
    endcase
    pins.row_address = row_hold;
    held_pins = pins;
    return pins;
  endfunction

  // --------------------------------------------------------------------------
  // Random helpers
  // --------------------------------------------------------------------------
  function automatic int unsigned draw_wait(idle_mode_t mode);
    case (mode)
      IDLE_NONE:   return 0;
      IDLE_SPARSE: return ($urandom_range(0, 7) == 0) ? $urandom_range(1, MAX_WAIT) : 0;
      default:     return $urandom_range(0, MAX_WAIT);
    endcase
  endfunction

  function automatic logic [rlms_pkg::COLOR_W-1:0] draw_level();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      default: return rlms_pkg::COLOR_W'($urandom_range(0, 255));
    endcase
  endfunction

  // mostly the rows of the pair being scanned, so writes show up on the pins
  function automatic logic [4:0] pick_row();
    if ($urandom_range(0, 9) < 6)
      return {1'($urandom_range(0, 1)), scan_pair};
    return 5'($urandom_range(0, 31));
  endfunction

  task automatic queue_pixel(logic [4:0] row, logic [5:0] col,
                             logic [7:0] r, logic [7:0] g, logic [7:0] b);
    rlms_pkg::in_item_t item;
    item.operation = rlms_pkg::OP_WRITE;
    item.pixel_row = row;
    item.pixel_col = col;
    item.red       = r;
    item.green     = g;
    item.blue      = b;
    pending_items.push_back(item);
  endtask

  // pixel fields of a tick carry random noise; the core must ignore them
  task automatic queue_tick(int unsigned count);
    rlms_pkg::in_item_t item;
    for (int unsigned n = 0; n < count; n++) begin
      item.operation = rlms_pkg::OP_TICK;
      item.pixel_row = 5'($urandom_range(0, 31));
      item.pixel_col = 6'($urandom_range(0, 63));
      item.red       = draw_level();
      item.green     = draw_level();
      item.blue      = draw_level();
      pending_items.push_back(item);
    end
  endtask

  task automatic queue_scan_mix(int unsigned count, int unsigned write_pct);
    for (int unsigned n = 0; n < count; n++) begin
      if ($urandom_range(0, 99) < write_pct)
        queue_pixel(pick_row(), 6'($urandom_range(0, 63)),
                    draw_level(), draw_level(), draw_level());
      else
        queue_tick(1);
    end
  endtask

  // Sender stays quiet until every item is in and every result is back.
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_items.size() != 0 || in_valid || expected_pins.size() != 0);
  endtask

  task automatic write_pulse_base(logic [rlms_pkg::PULSE_W-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(negedge clk);
    while (!cfg_ready);
    @(posedge clk);   // transfer happens on this edge
    pulse_base = value;
    cfg_valid <= 1'b0;
  endtask

  function automatic void check_pin(string name, logic [3:0] want, logic [3:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endfunction

  // --------------------------------------------------------------------------
  // Clock, reset and stimulus sequence
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    rst       = 1'b1;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    for (int i = 0; i < FRAME_DEPTH; i++) panel_frame[i] = '0;
    scan_pair  = '0;
    scan_plane = '0;
    scan_col   = '0;
    scan_phase = PH_SHIFT_LOW;
    lit_count  = '0;
    row_hold   = '0;
    pulse_base = rlms_pkg::PULSE_BASE_RESET;
    held_pins  = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed: a write before any tick echoes all-zero pins, corner pixels
    // with all-ones / all-zeros / alternating levels, then the first columns.
    queue_pixel(5'd0,  6'd0,  8'hFF, 8'h00, 8'hAA);
    queue_pixel(5'd16, 6'd0,  8'h00, 8'hFF, 8'h55);
    queue_pixel(5'd0,  6'd63, 8'hAA, 8'h55, 8'hFF);
    queue_pixel(5'd16, 6'd63, 8'hFF, 8'hFF, 8'hFF);
    queue_pixel(5'd31, 6'd63, 8'hFF, 8'hFF, 8'hFF);
    queue_pixel(5'd15, 6'd0,  8'h80, 8'h01, 8'h80);
    queue_pixel(5'd0,  6'd1,  8'h55, 8'hAA, 8'h00);
    queue_pixel(5'd17, 6'd1,  8'h01, 8'h80, 8'hFE);
    queue_tick(3);
    // write mid-shift: repeats the held clock-low pins, new value overwrites
    queue_pixel(5'd0,  6'd1,  8'h00, 8'h00, 8'h01);
    queue_tick(4);
    queue_pixel(5'd31, 6'd0,  8'h00, 8'h00, 8'h00);
    queue_tick(3);
    wait_drained();

    // Max pulse base; receiver holds off while the sender keeps streaming,
    // so the core backs up and drops in_ready.
    write_pulse_base(8'd255);
    send_mode = IDLE_NONE;
    recv_mode = IDLE_HEAVY;
    stall_requests++;
    queue_scan_mix(300, 15);
    wait_drained();

    // Smallest nonzero base: planes turn over fast; both sides idle heavily.
    write_pulse_base(8'd1);
    send_mode = IDLE_HEAVY;
    recv_mode = IDLE_HEAVY;
    queue_scan_mix(350, 15);
    wait_drained();

    write_pulse_base(8'($urandom_range(2, 254)));
    send_mode = IDLE_HEAVY;
    recv_mode = IDLE_NONE;
    queue_scan_mix(300, 15);
    wait_drained();

    // Zero base, one lit tick per plane: scatter pixels over the panel, then
    // scan with few writes so several planes go by.
    write_pulse_base(8'd0);
    send_mode = IDLE_SPARSE;
    recv_mode = IDLE_SPARSE;
    for (int n = 0; n < 100; n++)
      queue_pixel(5'($urandom_range(0, 31)), 6'($urandom_range(0, 63)),
                  draw_level(), draw_level(), draw_level());
    queue_scan_mix(480, 2);
    wait_drained();

    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && expected_pins.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Item driver: predicts on each input transfer, then presents the next item
  // after its drawn gap.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : item_driver
    logic busy;
    if (rst) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else begin
      busy = in_valid;
      if (in_valid && in_ready) begin
        expected_pins.push_back(advance_scan_model(in_data));
        busy = 1'b0;
      end
      if (!busy) begin
        if (send_gap != 0) begin
          in_valid <= 1'b0;
          send_gap <= send_gap - 1;
        end else if (pending_items.size() != 0) begin
          in_data  <= pending_items.pop_front();
          in_valid <= 1'b1;
          send_gap <= draw_wait(send_mode);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result monitor: checks each result transfer against the oldest prediction
  // and throttles out_ready; long hold-offs are counted here.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : result_monitor
    rlms_pkg::out_item_t want;
    logic took;
    int unsigned pause;
    if (rst) begin
      out_ready  <= 1'b0;
      recv_wait  <= 0;
      stall_left <= 0;
    end else begin
      took = out_valid && out_ready;
      if (took) begin
        if (expected_pins.size() == 0) begin
          $error("result transfer with no item outstanding");
          mismatch_count++;
        end else begin
          want = expected_pins.pop_front();
          check_pin("red_top",      want.red_top,      out_data.red_top);
          check_pin("green_top",    want.green_top,    out_data.green_top);
          check_pin("blue_top",     want.blue_top,     out_data.blue_top);
          check_pin("red_bottom",   want.red_bottom,   out_data.red_bottom);
          check_pin("green_bottom", want.green_bottom, out_data.green_bottom);
          check_pin("blue_bottom",  want.blue_bottom,  out_data.blue_bottom);
          check_pin("shift_clock",  want.shift_clock,  out_data.shift_clock);
          check_pin("latch",        want.latch,        out_data.latch);
          check_pin("display_on",   want.display_on,   out_data.display_on);
          check_pin("row_address",  want.row_address,  out_data.row_address);
          check_pin("frame_done",   want.frame_done,   out_data.frame_done);
        end
      end
      if (stall_left != 0) begin
        out_ready  <= 1'b0;
        stall_left <= stall_left - 1;
      end else if (stalls_served != stall_requests) begin
        stalls_served <= stalls_served + 1;
        stall_left    <= LONG_STALL;
        out_ready     <= 1'b0;
      end else if (took) begin
        pause = draw_wait(recv_mode);
        out_ready <= (pause == 0);
        recv_wait <= (pause == 0) ? 0 : pause - 1;
      end else if (recv_wait != 0) begin
        out_ready <= 1'b0;
        recv_wait <= recv_wait - 1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog: any stretch without a transfer on any channel past the limit.
  always @(posedge clk) begin : watchdog
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QUIET_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

endmodule
